FILE: rtl/shrp_pkg.sv
// shared types, constants and helpers for the 3x3 sharpen filter
// no dependencies; imported by every module of the block
`default_nettype none

package shrp_pkg;

   // image geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 10;
   localparam int DIM_W      = 11;

   // configuration register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // reset values, stored as last index (size minus one)
   localparam logic [COL_W-1:0] WIDTH_LAST_RESET  = 10'd639;
   localparam logic [ROW_W-1:0] HEIGHT_LAST_RESET = 10'd479;

   typedef logic [23:0] pixel_type;
   typedef logic [2:0][2:0][23:0] window_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_red;
      logic [7:0]       out_green;
      logic [7:0]       out_blue;
      logic [COL_W-1:0] out_col;
      logic [ROW_W-1:0] out_row;
      logic             last_of_run;
   } rsp_type;

   // edge flags of one result job
   typedef struct packed {
      logic first_row;
      logic first_col;
      logic last_col;
      logic last_row;
   } job_flags_type;

   // one job: window after the shift plus the position of its first result
   typedef struct packed {
      window_type       win;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      job_flags_type    flags;
   } job_type;

   // result order inside one job
   typedef enum logic [1:0] {
      PH_CENTER = 2'd0,
      PH_RIGHT  = 2'd1,
      PH_BELOW  = 2'd2,
      PH_CORNER = 2'd3
   } phase_type;

   // clamp a dimension register to 2..max and return its last index
   function automatic logic [9:0] dim_last(input logic [DIM_W-1:0] v,
                                           input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] clamped;
      clamped = v;
      if (v < 11'd2) begin
         clamped = 11'd2;
      end else if (v > maxv) begin
         clamped = maxv;
      end
      dim_last = 10'(clamped - 11'd1);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sharpen_3x3_rgb_filter_unit.sv
// 3x3 sharpen filter on a raster-order RGB stream, top level
// ties together shrp_front, shrp_job_fifo and shrp_back; uses shrp_pkg
//
// Usage:
//   req channel: one RGB pixel per request, in raster order, valid/ready.
//   rsp channel: sharpened pixels with their row and column, valid/ready;
//   last_of_run marks the final result caused by one request.
//   csr channel: index 0 sets image_width, index 1 image_height; a write to
//   either restarts the frame at row 0, column 0. Always ready.
// Timing:
//   the first result of a request passes the stage one register, the job
//   queue and the output register before it shows on rsp. Rows after the
//   first give one result per request except column zero, which gives none;
//   the last column gives two, the last row two and its last pixel four.
//   The back part issues one result per cycle while rsp is ready, so the rate
//   is one request per cycle except where a request causes extra results.
// Reset clears the counters, window and queue and restores 640x480; line
// store contents are left as they are. A stalled rsp side fills the output
// register and the two-entry job queue, then holds req_ready low.
`default_nettype none

module sharpen_3x3_rgb_filter_unit (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  shrp_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output shrp_pkg::rsp_type        rsp_data,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire  [1:0]               csr_index,
   input  wire  [10:0]              csr_wdata
);
   import shrp_pkg::*;

   logic    fj_valid;
   logic    fj_ready;
   job_type fj_data;
   logic    bj_valid;
   logic    bj_pop;
   job_type bj_data;

   // front: counters, line stores, window
   shrp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_valid (fj_valid),
      .job_ready (fj_ready),
      .job_data  (fj_data)
   );

   // job queue
   shrp_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fj_valid),
      .in_ready  (fj_ready),
      .in_data   (fj_data),
      .out_valid (bj_valid),
      .out_pop   (bj_pop),
      .out_data  (bj_data)
   );

   // back: kernel and result sequencing
   shrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (bj_valid),
      .job_pop   (bj_pop),
      .job_data  (bj_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/shrp_front.sv
// front part: config registers, position counters, line stores and 3x3 window
// uses shrp_pkg; emits one job per pixel that produces results
`default_nettype none

module shrp_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  shrp_pkg::req_type        req_data,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire  [1:0]               csr_index,
   input  wire  [10:0]              csr_wdata,
   output logic                     job_valid,
   input  wire                      job_ready,
   output shrp_pkg::job_type        job_data
);
   import shrp_pkg::*;

   logic [COL_W-1:0] width_last_ff, width_last_in;
   logic [ROW_W-1:0] height_last_ff, height_last_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             s1_valid_ff, s1_valid_in;
   pixel_type        s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   pixel_type        up_rd_ff;
   pixel_type        lo_rd_ff;

   pixel_type        line_upper [MAX_WIDTH];
   pixel_type        line_lower [MAX_WIDTH];

   window_type       win_ff, win_in;

   logic             accept;
   logic             csr_write;
   logic             s1_needs_job;
   logic             s1_adv;
   pixel_type        cur_pix;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign cur_pix   = {req_data.in_red, req_data.in_green, req_data.in_blue};

   // stage handshake
   assign s1_needs_job = (s1_row_ff != '0) && (s1_col_ff != '0);
   assign s1_adv       = s1_valid_ff && (!s1_needs_job || job_ready);
   assign req_ready    = !s1_valid_ff || s1_adv;
   assign accept       = req_valid && req_ready;
   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);

   // config registers and position counters
   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_last_in  = dim_last(csr_wdata, DIM_W'(MAX_WIDTH));
            CSR_IMAGE_HEIGHT: height_last_in = dim_last(csr_wdata, DIM_W'(MAX_HEIGHT));
            default: begin
               col_in = col_ff;
               row_in = row_ff;
            end
         endcase
      end else if (accept) begin
         if (col_ff == width_last_ff) begin
            col_in = '0;
            row_in = (row_ff == height_last_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= WIDTH_LAST_RESET;
         height_last_ff <= HEIGHT_LAST_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff <= cur_pix;
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
      end
   end

   // lower line store: read old entry, write current pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         lo_rd_ff           <= line_lower[col_ff];
         line_lower[col_ff] <= cur_pix;
      end
   end

   // upper line store: read on accept, takes the old lower entry when stage one advances
   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff <= line_upper[col_ff];
      end
      if (s1_adv) begin
         line_upper[s1_col_ff] <= lo_rd_ff;
      end
   end

   // window shift
   always_comb begin
      win_in = win_ff;
      for (int x = 0; x < 3; x++) begin
         win_in[x][0] = win_ff[x][1];
         win_in[x][1] = win_ff[x][2];
      end
      win_in[0][2] = up_rd_ff;
      win_in[1][2] = lo_rd_ff;
      win_in[2][2] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   // job out
   assign job_valid               = s1_valid_ff && s1_needs_job;
   assign job_data.win            = win_in;
   assign job_data.col            = s1_col_ff - 1'b1;
   assign job_data.row            = s1_row_ff - 1'b1;
   assign job_data.flags.first_row = (s1_row_ff == ROW_W'(1));
   assign job_data.flags.first_col = (s1_col_ff == COL_W'(1));
   assign job_data.flags.last_col  = (s1_col_ff == width_last_ff);
   assign job_data.flags.last_row  = (s1_row_ff == height_last_ff);

endmodule

`default_nettype wire

FILE: rtl/shrp_job_fifo.sv
// two-entry job queue between the front and the back parts
// uses shrp_pkg for the job type
`default_nettype none

module shrp_job_fifo (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  shrp_pkg::job_type        in_data,
   output logic                     out_valid,
   input  wire                      out_pop,
   output shrp_pkg::job_type        out_data
);
   import shrp_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   // pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/shrp_back.sv
// back part: walks the one to four results of a job and computes the kernel
// uses shrp_pkg; drives the registered result channel
`default_nettype none

module shrp_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      job_valid,
   output logic                     job_pop,
   input  shrp_pkg::job_type        job_data,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output shrp_pkg::rsp_type        rsp_data
);
   import shrp_pkg::*;

   phase_type     phase_ff, phase_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   job_flags_type fl;
   logic          load;
   logic          done;
   logic [1:0]    tr, cr, br, lc, cc, rc;
   pixel_type     p_c, p_t, p_b, p_l, p_r;
   logic [7:0]    chan_out [3];

   assign fl   = job_data.flags;
   assign load = job_valid && (!rsp_valid_ff || rsp_ready);

   // result sequencing
   always_comb begin
      phase_in = phase_ff;
      done     = 1'b1;
      tr = fl.first_row ? 2'd1 : 2'd0;
      cr = 2'd1;
      br = 2'd2;
      lc = fl.first_col ? 2'd1 : 2'd0;
      cc = 2'd1;
      rc = 2'd2;
      unique case (phase_ff)
         PH_CENTER: begin
            if (fl.last_col) begin
               done     = 1'b0;
               phase_in = PH_RIGHT;
            end else if (fl.last_row) begin
               done     = 1'b0;
               phase_in = PH_BELOW;
            end
         end
         PH_RIGHT: begin
            lc = 2'd1;
            cc = 2'd2;
            if (fl.last_row) begin
               done     = 1'b0;
               phase_in = PH_BELOW;
            end
         end
         PH_BELOW: begin
            tr = 2'd1;
            cr = 2'd2;
            if (fl.last_col) begin
               done     = 1'b0;
               phase_in = PH_CORNER;
            end
         end
         PH_CORNER: begin
            tr = 2'd1;
            cr = 2'd2;
            lc = 2'd1;
            cc = 2'd2;
         end
         default: begin
            done = 1'b1;
         end
      endcase
      if (!load) begin
         phase_in = phase_ff;
      end else if (done) begin
         phase_in = PH_CENTER;
      end
   end

   assign job_pop = load && done;

   // neighborhood select
   assign p_c = job_data.win[cr][cc];
   assign p_t = job_data.win[tr][cc];
   assign p_b = job_data.win[br][cc];
   assign p_l = job_data.win[cr][lc];
   assign p_r = job_data.win[cr][rc];

   // kernel per channel: 5*centre minus four neighbors, clamped to 0..255
   always_comb begin
      logic signed [11:0] acc;
      logic [11:0]        ctr;
      for (int j = 0; j < 3; j++) begin
         ctr = {4'b0, p_c[j*8 +: 8]};
         acc = $signed((ctr << 2) + ctr
                       - {4'b0, p_t[j*8 +: 8]} - {4'b0, p_b[j*8 +: 8]}
                       - {4'b0, p_l[j*8 +: 8]} - {4'b0, p_r[j*8 +: 8]});
         if (acc < 0) begin
            chan_out[j] = 8'd0;
         end else if (acc > 12'sd255) begin
            chan_out[j] = 8'd255;
         end else begin
            chan_out[j] = acc[7:0];
         end
      end
   end

   // output register
   always_comb begin
      rsp_data_in              = rsp_data_ff;
      rsp_valid_in             = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_red     = chan_out[2];
         rsp_data_in.out_green   = chan_out[1];
         rsp_data_in.out_blue    = chan_out[0];
         rsp_data_in.out_col     = (cc == 2'd2) ? job_data.col + 1'b1 : job_data.col;
         rsp_data_in.out_row     = (cr == 2'd2) ? job_data.row + 1'b1 : job_data.row;
         rsp_data_in.last_of_run = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CENTER;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: sim/sharpen_3x3_rgb_filter_unit_checker.sv
// checker for the 3x3 sharpen filter: watches the request, result and csr channels
// keeps its own line stores, window and counters to predict every sharpened pixel
// depends on shrp_pkg for the payload types, register indexes and size limits
module sharpen_3x3_rgb_filter_unit_checker
   import shrp_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_ready,
   input  req_type     req_data,
   input  wire         rsp_valid,
   input  wire         rsp_ready,
   input  rsp_type     rsp_data,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [10:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SHOWN_MISMATCHES = 10;

   // predicted copy of the block state
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   pixel_type        upper_line [MAX_WIDTH];
   pixel_type        lower_line [MAX_WIDTH];
   pixel_type        win [3][3];
   int               col_count;
   int               row_count;
   rsp_type          sharpened_q [$];

   // register value limited to 2..maxv
   function automatic int clamp_dim(input int v, input int maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // 5*centre minus the top, bottom, left and right neighbours of a channel, saturated to a byte
   function automatic logic [7:0] sharpen_channel(input pixel_type ctr, input pixel_type top,
                                                  input pixel_type bot, input pixel_type lft,
                                                  input pixel_type rgt, input int sh);
      int v;
      v = 5 * int'(ctr[sh +: 8]) - int'(top[sh +: 8]) - int'(bot[sh +: 8])
          - int'(lft[sh +: 8]) - int'(rgt[sh +: 8]);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   // one sharpened pixel from the chosen window rows and columns
   function automatic rsp_type sharpen_at(input int tr, input int cr, input int br,
                                          input int lc, input int cc, input int rc,
                                          input int col, input int row);
      rsp_type   res;
      pixel_type ctr, top, bot, lft, rgt;
      ctr = win[cr][cc];
      top = win[tr][cc];
      bot = win[br][cc];
      lft = win[cr][lc];
      rgt = win[cr][rc];
      res.out_red     = sharpen_channel(ctr, top, bot, lft, rgt, 16);
      res.out_green   = sharpen_channel(ctr, top, bot, lft, rgt, 8);
      res.out_blue    = sharpen_channel(ctr, top, bot, lft, rgt, 0);
      res.out_col     = COL_W'(col);
      res.out_row     = ROW_W'(row);
      res.last_of_run = 1'b0;
      return res;
   endfunction

   // take one pixel: update line stores and window, queue the results it releases
   task automatic sharpen_step(input req_type px);
      int        w, h, c, r, n, tr, lc;
      pixel_type cur, up, lo;
      rsp_type   batch [4];
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      c = col_count;
      r = row_count;
      n = 0;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      cur = {px.in_red, px.in_green, px.in_blue};
      up  = upper_line[c];
      lo  = lower_line[c];
      upper_line[c] = lo;
      lower_line[c] = cur;
      for (int x = 0; x < 3; x++) begin
         win[x][0] = win[x][1];
         win[x][1] = win[x][2];
      end
      win[0][2] = up;
      win[1][2] = lo;
      win[2][2] = cur;

      // top edge and left edge reuse the centre pixel
      if (r >= 1 && c >= 1) begin
         tr = (r == 1) ? 1 : 0;
         lc = (c == 1) ? 1 : 0;
         batch[n] = sharpen_at(tr, 1, 2, lc, 1, 2, c - 1, r - 1);
         n = n + 1;
         if (c == w - 1) begin
            batch[n] = sharpen_at(tr, 1, 2, 1, 2, 2, w - 1, r - 1);
            n = n + 1;
         end
         // bottom row flushed while the last row streams in
         if (r == h - 1) begin
            batch[n] = sharpen_at(1, 2, 2, lc, 1, 2, c - 1, r);
            n = n + 1;
            if (c == w - 1) begin
               batch[n] = sharpen_at(1, 2, 2, 1, 2, 2, w - 1, r);
               n = n + 1;
            end
         end
         batch[n - 1].last_of_run = 1'b1;
         for (int k = 0; k < n; k++) sharpened_q.push_back(batch[k]);
      end

      c = c + 1;
      if (c >= w) begin
         c = 0;
         r = r + 1;
         if (r >= h) r = 0;
      end
      col_count = c;
      row_count = r;
   endtask

   // compare one delivered pixel with the oldest prediction
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (sharpened_q.size() == 0) begin
         fail_count++;
         if (fail_count <= SHOWN_MISMATCHES)
            $display("unexpected result: rgb=%0d,%0d,%0d col=%0d row=%0d last=%0d",
                     got.out_red, got.out_green, got.out_blue, got.out_col, got.out_row,
                     got.last_of_run);
      end else begin
         want = sharpened_q.pop_front();
         if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
             got.out_blue !== want.out_blue || got.out_col !== want.out_col ||
             got.out_row !== want.out_row || got.last_of_run !== want.last_of_run) begin
            fail_count++;
            if (fail_count <= SHOWN_MISMATCHES)
               $display("mismatch: expected rgb=%0d,%0d,%0d col=%0d row=%0d last=%0d, got rgb=%0d,%0d,%0d col=%0d row=%0d last=%0d",
                        want.out_red, want.out_green, want.out_blue, want.out_col,
                        want.out_row, want.last_of_run, got.out_red, got.out_green,
                        got.out_blue, got.out_col, got.out_row, got.last_of_run);
         end
      end
   endtask

   // sample all three channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         width_reg  = 11'd640;
         height_reg = 11'd480;
         col_count  = 0;
         row_count  = 0;
         fail_count = 0;
         for (int x = 0; x < 3; x++)
            for (int y = 0; y < 3; y++) win[x][y] = '0;
         sharpened_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         // a write to a known register restarts the frame
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH) begin
               width_reg = csr_wdata;
               col_count = 0;
               row_count = 0;
            end else if (csr_index == CSR_IMAGE_HEIGHT) begin
               height_reg = csr_wdata;
               col_count  = 0;
               row_count  = 0;
            end
         end
         if (req_valid && req_ready) sharpen_step(req_data);
      end
      pending_count = sharpened_q.size();
   end

endmodule

FILE: sim/sharpen_3x3_rgb_filter_unit_tb.sv
// testbench top for sharpen_3x3_rgb_filter_unit: clock, reset, pixel and csr stimulus
// result-side back-pressure and the verdict; checking lives in the checker module
// depends on shrp_pkg, the filter rtl and sharpen_3x3_rgb_filter_unit_checker
module sharpen_3x3_rgb_filter_unit_tb;
   import shrp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // register indexes the block must ignore
   localparam logic [1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [1:0] CSR_SPARE_HIGH = 2'd3;
   localparam int         SETTLE_CYCLES  = 16;
   localparam int         LONG_HOLD      = 150;
   localparam int         RANDOM_ITEMS   = 110;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [10:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   bit          sender_eager  = 1'b0;
   bit          long_hold_go  = 1'b0;
   bit          long_hold_done = 1'b0;

   always #1 clock = ~clock;

   sharpen_3x3_rgb_filter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sharpen_3x3_rgb_filter_unit_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 2);
      return $urandom_range(6, 24);
   endfunction

   // random channel, pushed to the clamp limits a quarter of the time
   function automatic logic [7:0] rand_channel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic req_type rand_pixel();
      req_type px;
      px.in_red   = rand_channel();
      px.in_green = rand_channel();
      px.in_blue  = rand_channel();
      return px;
   endfunction

   // offer one pixel request and hold it until taken, then maybe go idle
   task automatic send_pixel(input req_type px);
      int gap;
      req_data  <= px;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      gap = 0;
      if (!sender_eager && $urandom_range(0, 99) < 35) gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // one csr write; csr_valid is dropped again before the task returns
   task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // stop sending, drain every expected result and let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // result side: random stalls, gapless stretches and one long hold-off
   initial begin
      int run_left;
      int stall_left;
      bit eager;
      run_left   = 0;
      stall_left = 0;
      eager      = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_go && !long_hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_done = 1'b1;
         end else begin
            if (run_left == 0) begin
               eager    = ($urandom_range(0, 3) == 0);
               run_left = $urandom_range(10, 80);
            end
            run_left--;
            if (eager) begin
               rsp_ready <= 1'b1;
            end else if (stall_left > 0) begin
               rsp_ready <= 1'b0;
               stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
               rsp_ready <= 1'b0;
               stall_left = pick_gap() - 1;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // stimulus and verdict
   initial begin
      req_type px;
      int      w, h, eff_w, eff_h, count, random_count;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset geometry: a few pixels of the first row, no results yet
      repeat (4) send_pixel(rand_pixel());
      settle();

      // smallest frame with extreme pixels
      write_reg(CSR_IMAGE_WIDTH, 11'd2);
      write_reg(CSR_IMAGE_HEIGHT, 11'd2);
      px = '{in_red: 8'd255, in_green: 8'd0, in_blue: 8'd255};
      send_pixel(px);
      px = '{in_red: 8'd0, in_green: 8'd255, in_blue: 8'd0};
      send_pixel(px);
      px = '{in_red: 8'd0, in_green: 8'd0, in_blue: 8'd0};
      send_pixel(px);
      px = '{in_red: 8'd255, in_green: 8'd255, in_blue: 8'd255};
      send_pixel(px);
      settle();

      // checkerboard drives both clamp limits
      write_reg(CSR_IMAGE_WIDTH, 11'd3);
      write_reg(CSR_IMAGE_HEIGHT, 11'd3);
      for (int rr = 0; rr < 3; rr++) begin
         for (int cc = 0; cc < 3; cc++) begin
            px.in_red   = ((rr + cc) % 2 == 1) ? 8'd255 : 8'd0;
            px.in_green = ((rr + cc) % 2 == 1) ? 8'd0 : 8'd255;
            px.in_blue  = 8'(rr * 40 + cc * 13);
            send_pixel(px);
         end
      end
      settle();

      // registers below range clamp to 2x2; run past the frame wrap
      write_reg(CSR_IMAGE_WIDTH, 11'd0);
      write_reg(CSR_IMAGE_HEIGHT, 11'd1);
      repeat (6) send_pixel(rand_pixel());
      settle();
      // unused indexes leave the frame position alone
      write_reg(CSR_SPARE_LOW, 11'h7ff);
      write_reg(CSR_SPARE_HIGH, 11'd0);
      repeat (2) send_pixel(rand_pixel());
      settle();

      // widest frame, clamped from all ones; the first row gives no results
      write_reg(CSR_IMAGE_WIDTH, 11'h7ff);
      write_reg(CSR_IMAGE_HEIGHT, 11'd2);
      repeat (10) send_pixel(rand_pixel());
      settle();

      // full small frame against a long result hold-off
      write_reg(CSR_IMAGE_WIDTH, 11'd4);
      write_reg(CSR_IMAGE_HEIGHT, 11'd6);
      sender_eager = 1'b1;
      long_hold_go = 1'b1;
      repeat (24) send_pixel(rand_pixel());
      sender_eager = 1'b0;
      settle();

      // tallest frame clamped from above range, only the first rows
      write_reg(CSR_IMAGE_WIDTH, 11'd2);
      write_reg(CSR_IMAGE_HEIGHT, 11'd1025);
      repeat (12) send_pixel(rand_pixel());
      settle();

      // random small frames, mostly complete ones
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         w = $urandom_range(0, 9);
         h = $urandom_range(0, 6);
         eff_w = (w < 2) ? 2 : w;
         eff_h = (h < 2) ? 2 : h;
         if ($urandom_range(0, 1) == 0) begin
            write_reg(CSR_IMAGE_WIDTH, 11'(w));
            write_reg(CSR_IMAGE_HEIGHT, 11'(h));
         end else begin
            write_reg(CSR_IMAGE_HEIGHT, 11'(h));
            write_reg(CSR_IMAGE_WIDTH, 11'(w));
         end
         if ($urandom_range(0, 9) < 7) count = eff_w * eff_h * $urandom_range(1, 2);
         else count = $urandom_range(1, eff_w * eff_h);
         if (count > RANDOM_ITEMS - random_count) count = RANDOM_ITEMS - random_count;
         sender_eager = ($urandom_range(0, 3) == 0);
         repeat (count) send_pixel(rand_pixel());
         random_count += count;
         settle();
      end

      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: sharpen_3x3_rgb_filter_unit.f
rtl/shrp_pkg.sv
rtl/shrp_front.sv
rtl/shrp_job_fifo.sv
rtl/shrp_back.sv
rtl/sharpen_3x3_rgb_filter_unit.sv
sim/sharpen_3x3_rgb_filter_unit_checker.sv
sim/sharpen_3x3_rgb_filter_unit_tb.sv
